/* src/dmxr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DMX receiver package
// Shared widths, constants and payload types of the DMX frame receiver.
// ----------------------------------------------------------------------------
package dmxr_pkg;

  localparam int BOARD_CHANNELS = 16;
  localparam int UNIVERSE_SLOTS = 512;

  localparam int DATA_W  = 8;
  localparam int ADDR_W  = 5;
  localparam int CHAN_W  = 4;
  localparam int SLOT_W  = 10;
  localparam int PHASE_W = 2;

  // One received UART byte with its framing-error flag.
  typedef struct packed {
    logic [DATA_W-1:0] rx_byte;
    logic              framing_error;
  } dmxr_item_t;

  // One result: the store write made by a byte and the state after it.
  typedef struct packed {
    logic               store_write;
    logic [CHAN_W-1:0]  channel_slot;
    logic [DATA_W-1:0]  channel_value;
    logic [PHASE_W-1:0] frame_state;
  } dmxr_result_t;

endpackage

/* src/dmxr_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DMX receiver input channel
// Valid/ready channel that carries one received byte per transaction.
// ----------------------------------------------------------------------------
interface dmxr_in_if
  import dmxr_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] rx_byte;
  logic              framing_error;

  modport source (output valid, output rx_byte, output framing_error, input ready);
  modport sink   (input valid, input rx_byte, input framing_error, output ready);
endinterface

/* src/dmxr_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DMX receiver result channel
// Valid/ready channel that carries one result per transaction.
// ----------------------------------------------------------------------------
interface dmxr_out_if
  import dmxr_pkg::*;
;
  logic               valid;
  logic               ready;
  logic               store_write;
  logic [CHAN_W-1:0]  channel_slot;
  logic [DATA_W-1:0]  channel_value;
  logic [PHASE_W-1:0] frame_state;

  modport source (output valid, output store_write, output channel_slot,
                  output channel_value, output frame_state, input ready);
  modport sink   (input valid, input store_write, input channel_slot,
                  input channel_value, input frame_state, output ready);
endinterface

/* src/dmx_frame_channel_receiver.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DMX frame channel receiver
// Tracks DMX512 frames from received UART bytes and reports the slot
// bytes that fall into this board's sixteen-channel window.
// ----------------------------------------------------------------------------
// Usage:
// The in_if channel takes one transaction per received UART byte, with its
// framing-error flag; a framing error is how a break shows up. The out_if
// channel returns exactly one result transaction per input byte: whether
// the byte was written to a local channel, which channel (0 to 15), the
// value, and the frame state after the byte (0 waiting for break, 1 waiting
// for the start code, 2 reading slots). The channel store itself lives
// downstream; the results carry every write to it in order.
// The cfg port sets the board number; the window covers slots from board
// number times sixteen on. Write it only while the block is idle.
// An accepted byte waits in the input register until the result register
// can load, and the frame sequencer's result for it is then loaded into
// the result register. Throughput is one byte per cycle while the result
// sink keeps ready high, set by the sequencer step between the registers.
// After reset the sequencer waits for a break, the slot counter and board
// number are zero and both registers are empty. When the result sink
// stalls, the full result register holds its result, the input register
// keeps its byte, and in_if.ready drops until the stall clears.
// ----------------------------------------------------------------------------
module dmx_frame_channel_receiver
  import dmxr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  dmxr_in_if.sink           in_if,
  dmxr_out_if.source        out_if,
  input  logic              cfg_we,
  input  logic [ADDR_W-1:0] cfg_wdata
);

  // Board number register.
  logic [ADDR_W-1:0] board_address_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      board_address_r <= '0;
    end else if (cfg_we) begin
      board_address_r <= cfg_wdata;
    end
  end

  // Input register. The byte advances into the sequencer whenever the
  // result register is free or being emptied in the same cycle.
  logic         in_valid_r;
  dmxr_item_t   in_item_r;
  logic         out_can_load;
  logic         step_en;
  dmxr_result_t step_result;
  dmxr_result_t out_result;

  assign step_en     = in_valid_r && out_can_load;
  assign in_if.ready = !in_valid_r || out_can_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      in_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      in_item_r.rx_byte       <= in_if.rx_byte;
      in_item_r.framing_error <= in_if.framing_error;
    end
  end

  // Frame sequencer: one step per byte.
  dmxr_frame_fsm u_fsm (
    .clk           (clk),
    .rst_n         (rst_n),
    .step_en       (step_en),
    .item          (in_item_r),
    .board_address (board_address_r),
    .result        (step_result)
  );

  // Result register facing the sink.
  dmxr_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (step_en),
    .result_in  (step_result),
    .ready      (out_if.ready),
    .valid      (out_if.valid),
    .can_load   (out_can_load),
    .result_out (out_result)
  );

  assign out_if.store_write   = out_result.store_write;
  assign out_if.channel_slot  = out_result.channel_slot;
  assign out_if.channel_value = out_result.channel_value;
  assign out_if.frame_state   = out_result.frame_state;

endmodule

/* src/dmxr_frame_fsm.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DMX frame sequencer
// Break / start code / slot state machine with the slot counter and the
// board window test. Produces the result of the byte stepped this cycle.
// ----------------------------------------------------------------------------
module dmxr_frame_fsm
  import dmxr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  dmxr_item_t        item,
  input  logic [ADDR_W-1:0] board_address,
  output dmxr_result_t      result
);

  typedef enum logic [PHASE_W-1:0] {
    PH_BREAK = 2'd0,
    PH_START = 2'd1,
    PH_READ  = 2'd2
  } phase_t;

  phase_t            phase_r, phase_nxt;
  logic [SLOT_W-1:0] slot_cnt_r, slot_cnt_nxt;

  logic [SLOT_W-1:0] win_first;
  logic [SLOT_W-1:0] win_last;
  logic [SLOT_W-1:0] local_idx;
  logic              in_window;

  assign win_first = SLOT_W'(board_address) * SLOT_W'(BOARD_CHANNELS);
  assign win_last  = win_first + SLOT_W'(BOARD_CHANNELS - 1);
  assign local_idx = slot_cnt_r - win_first;
  assign in_window = (slot_cnt_r >= win_first) && (slot_cnt_r <= win_last) &&
                     (local_idx < SLOT_W'(BOARD_CHANNELS));

  always_comb begin
    phase_nxt             = phase_r;
    slot_cnt_nxt          = slot_cnt_r;
    result.store_write    = 1'b0;
    result.channel_slot   = '0;
    result.channel_value  = '0;
    case (phase_r)
      PH_START: begin
        if (!item.framing_error) begin
          if (item.rx_byte == '0) begin
            slot_cnt_nxt = '0;
            phase_nxt    = PH_READ;
          end else begin
            phase_nxt = PH_BREAK;
          end
        end
      end
      PH_READ: begin
        if (item.framing_error) begin
          phase_nxt = PH_BREAK;
        end else if (slot_cnt_r >= SLOT_W'(UNIVERSE_SLOTS)) begin
          phase_nxt = PH_BREAK;
        end else begin
          if (in_window) begin
            result.store_write   = 1'b1;
            result.channel_slot  = local_idx[CHAN_W-1:0];
            result.channel_value = item.rx_byte;
          end
          slot_cnt_nxt = slot_cnt_r + 1'b1;
        end
      end
      default: begin
        phase_nxt = item.framing_error ? PH_START : PH_BREAK;
      end
    endcase
    result.frame_state = phase_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_BREAK;
      slot_cnt_r <= '0;
    end else if (step_en) begin
      phase_r    <= phase_nxt;
      slot_cnt_r <= slot_cnt_nxt;
    end
  end

endmodule

/* src/dmxr_out_reg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DMX receiver result register
// Holds one result until the sink takes it; reports when it can load.
// ----------------------------------------------------------------------------
module dmxr_out_reg
  import dmxr_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         load,
  input  dmxr_result_t result_in,
  input  logic         ready,
  output logic         valid,
  output logic         can_load,
  output dmxr_result_t result_out
);

  logic         valid_r;
  dmxr_result_t data_r;

  assign can_load   = !valid_r || ready;
  assign valid      = valid_r;
  assign result_out = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= result_in;
    end
  end

endmodule

/* tb/dmx_frame_channel_receiver_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DMX frame channel receiver testbench
// Drives received bytes with framing flags through the input channel, runs
// a cycle-free model of the DMX receive sequence next to the block, and
// checks every result transaction field by field against that model. Both
// channels idle at random, and the board number is changed between phases.
// ----------------------------------------------------------------------------
module dmx_frame_channel_receiver_tb;
  import dmxr_pkg::*;

  localparam int HALF_PERIOD  = 5;
  localparam int RESET_CYCLES = 10;
  localparam int MAX_IDLE     = 12;
  // Cycles the block may keep working after its last result transaction.
  localparam int SETTLE_CYCLES = 6;
  // Cycles with no transaction on either channel before the run is abandoned.
  localparam int STALL_LIMIT = 2000;

  // Receive sequence phases, in the encoding that frame_state reports.
  typedef enum logic [PHASE_W-1:0] {
    PH_WAIT_BREAK = 2'd0,
    PH_WAIT_START = 2'd1,
    PH_READING    = 2'd2
  } frame_phase_e;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  logic [ADDR_W-1:0] cfg_wdata;

  dmxr_in_if  in_ch ();
  dmxr_out_if out_ch ();

  dmx_frame_channel_receiver dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #HALF_PERIOD clk = ~clk;

  // Model state: the sequencer phase, the slot counter and the board number
  // as the block should hold them after every accepted byte.
  frame_phase_e      rx_phase_q;
  logic [SLOT_W-1:0] slot_count_q;
  logic [ADDR_W-1:0] board_q;

  // Results the block still owes, oldest first.
  dmxr_result_t pending_results[$];

  int error_count = 0;
  int bytes_sent  = 0;
  int quiet_cycles = 0;
  bit src_paced  = 1'b1;
  bit sink_paced = 1'b1;

  task automatic report_error(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    error_count++;
  endtask

  // Advances the model by one byte and returns the result it must produce.
  // A break arms the receiver, a zero start code opens a frame, and each clean
  // byte of an open frame is one slot; slots inside this board's window are
  // reported as store writes with their local channel index.
  function automatic dmxr_result_t model_rx_byte(input logic [DATA_W-1:0] data,
                                                 input logic ferr);
    dmxr_result_t res;
    int unsigned  window_base;
    int unsigned  chan_idx;
    res         = '0;
    window_base = board_q * BOARD_CHANNELS;
    case (rx_phase_q)
      PH_WAIT_START: begin
        // A second break while armed changes nothing.
        if (!ferr) begin
          if (data == '0) begin
            slot_count_q = '0;
            rx_phase_q   = PH_READING;
          end else begin
            rx_phase_q = PH_WAIT_BREAK;
          end
        end
      end
      PH_READING: begin
        // A break mid-frame abandons it, and so does a slot past the
        // universe; the counter stays where it is in both cases.
        if (ferr || slot_count_q >= UNIVERSE_SLOTS) begin
          rx_phase_q = PH_WAIT_BREAK;
        end else begin
          if (slot_count_q >= window_base &&
              slot_count_q < window_base + BOARD_CHANNELS) begin
            chan_idx          = slot_count_q - window_base;
            res.store_write   = 1'b1;
            res.channel_slot  = chan_idx[CHAN_W-1:0];
            res.channel_value = data;
          end
          slot_count_q = slot_count_q + 1'b1;
        end
      end
      default: begin
        rx_phase_q = ferr ? PH_WAIT_START : PH_WAIT_BREAK;
      end
    endcase
    res.frame_state = rx_phase_q;
    return res;
  endfunction

  // Presents one byte, holds it until the block takes it, then records what
  // the block must return for it. Ready is sampled on the falling edge, where
  // both sides of the handshake are settled, and the transaction completes at
  // the following rising edge.
  task automatic send_byte(input logic [DATA_W-1:0] data, input logic ferr);
    int gap;
    bit taken;
    if ($urandom_range(0, 99) == 0) begin
      src_paced = !src_paced;
    end
    gap = src_paced ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.rx_byte       <= data;
    in_ch.framing_error <= ferr;
    do begin
      @(negedge clk);
      taken = in_ch.ready;
      @(posedge clk);
    end while (!taken);
    pending_results.push_back(model_rx_byte(data, ferr));
    bytes_sent++;
  endtask

  // Stops sending and waits until every owed result has come back, then for
  // SETTLE_CYCLES more for anything in flight. The watchdog covers a lost result.
  task automatic wait_for_results_drained();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_board_address(input logic [ADDR_W-1:0] addr);
    wait_for_results_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= addr;
    @(posedge clk);
    cfg_we  <= 1'b0;
    board_q  = addr;
  endtask

  // Sends breaks until the model says the receiver is armed for a start code.
  task automatic arm_receiver();
    while (rx_phase_q != PH_WAIT_START) begin
      send_byte(DATA_W'($urandom_range(0, 255)), 1'b1);
    end
  endtask

  // Out of reset the receiver ignores clean bytes until it sees a break.
  task automatic test_idle_after_reset();
    send_byte(8'h00, 1'b0);
  endtask

  // A full frame on board 0: a repeated break while armed, the start code, the
  // whole window with both extreme byte values, one slot past the window, and
  // then a break that abandons the frame.
  task automatic test_board0_frame();
    logic [DATA_W-1:0] slot_bytes[17] = '{
      8'h00, 8'hFF, 8'h01, 8'h80, 8'h55, 8'hAA, 8'h02, 8'h40,
      8'h04, 8'h20, 8'h08, 8'h10, 8'hFE, 8'h7F, 8'hC3, 8'hFF, 8'h7E
    };
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'h00, 1'b0);
    foreach (slot_bytes[i]) begin
      send_byte(slot_bytes[i], 1'b0);
    end
    send_byte(8'h00, 1'b1);
  endtask

  // A nonzero start code drops the receiver back to waiting for a break, so
  // the clean byte after it is ignored.
  task automatic test_bad_start_code();
    arm_receiver();
    send_byte(8'h80, 1'b0);
    send_byte(8'h00, 1'b0);
  endtask

  // Random traffic for one board number. Most sequences are well-formed frames,
  // some very short and the others ending near the board's window, from just
  // before it to just past it; the rest are frames with a bad start code and
  // plain noise. A frame may be cut short by a break, and a frame still running
  // when the byte budget is spent is left unfinished. On the top board the
  // phase opens with a frame that runs past the end of the universe.
  task automatic test_random_traffic(input logic [ADDR_W-1:0] addr, input int budget);
    int stop_at;
    int kind;
    int slot_total;
    int abort_at;
    int window_base;
    bit overlong;
    write_board_address(addr);
    stop_at     = bytes_sent + budget;
    window_base = addr * BOARD_CHANNELS;
    overlong    = (addr == {ADDR_W{1'b1}});
    while (bytes_sent < stop_at) begin
      kind = overlong ? 0 : $urandom_range(0, 99);
      if (kind < 70) begin
        arm_receiver();
        if ($urandom_range(0, 4) == 0) begin
          send_byte(DATA_W'($urandom_range(0, 255)), 1'b1);
        end
        send_byte(8'h00, 1'b0);
        if (overlong) begin
          slot_total = UNIVERSE_SLOTS + $urandom_range(1, 3);
          overlong   = 1'b0;
        end else if ($urandom_range(0, 4) == 0) begin
          slot_total = $urandom_range(0, 6);
        end else begin
          slot_total = $urandom_range(window_base > 3 ? window_base - 3 : 0,
                                      window_base + BOARD_CHANNELS + 3);
        end
        abort_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, slot_total) : -1;
        for (int s = 0; s < slot_total; s++) begin
          if (bytes_sent >= stop_at) begin
            break;
          end
          if (s == abort_at) begin
            send_byte(DATA_W'($urandom_range(0, 255)), 1'b1);
            break;
          end
          send_byte(DATA_W'($urandom_range(0, 255)), 1'b0);
        end
      end else if (kind < 85) begin
        arm_receiver();
        send_byte(DATA_W'($urandom_range(1, 255)), 1'b0);
        repeat ($urandom_range(0, 3)) send_byte(DATA_W'($urandom_range(0, 255)), 1'b0);
      end else begin
        repeat ($urandom_range(1, 6)) begin
          send_byte(DATA_W'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
        end
      end
    end
  endtask

  // Stimulus sequence. Reset is held for RESET_CYCLES clocks and never
  // asserted again; the board number is written between phases only.
  initial begin
    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_wdata           <= '0;
    in_ch.valid         <= 1'b0;
    in_ch.rx_byte       <= '0;
    in_ch.framing_error <= 1'b0;
    rx_phase_q   = PH_WAIT_BREAK;
    slot_count_q = '0;
    board_q      = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_board_address('0);
    test_idle_after_reset();
    test_board0_frame();
    test_bad_start_code();

    test_random_traffic(5'd0, 600);
    test_random_traffic(5'd1, 300);
    test_random_traffic(ADDR_W'($urandom_range(2, 7)), 400);
    test_random_traffic(5'd31, 520);

    wait_for_results_drained();
    if (error_count == 0) begin
      $display("dmx_frame_channel_receiver_tb OK");
    end else begin
      $display("dmx_frame_channel_receiver_tb NOT OK");
    end
    $finish;
  end

  // Result sink: before each result transaction it may hold ready low for a
  // random number of cycles, and it switches between stalling and streaming
  // now and then so that long runs at full rate occur too.
  initial begin
    int stall;
    bit taken;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 99) == 0) begin
        sink_paced = !sink_paced;
      end
      stall = sink_paced ? $urandom_range(0, MAX_IDLE) : 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do begin
        @(negedge clk);
        taken = out_ch.valid;
        @(posedge clk);
      end while (!taken);
    end
  end

  // Result checker. A result transaction seen with valid and ready high on the
  // falling edge completes at the next rising edge, so it is compared here
  // against the oldest owed result.
  always @(negedge clk) begin
    dmxr_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_error("result transaction with no byte waiting for it");
      end else begin
        want = pending_results.pop_front();
        if (out_ch.store_write !== want.store_write) begin
          report_error($sformatf("store_write %0b, model %0b",
                                 out_ch.store_write, want.store_write));
        end
        if (out_ch.channel_slot !== want.channel_slot) begin
          report_error($sformatf("channel_slot %0d, model %0d",
                                 out_ch.channel_slot, want.channel_slot));
        end
        if (out_ch.channel_value !== want.channel_value) begin
          report_error($sformatf("channel_value 0x%02h, model 0x%02h",
                                 out_ch.channel_value, want.channel_value));
        end
        if (out_ch.frame_state !== want.frame_state) begin
          report_error($sformatf("frame_state %0d, model %0d",
                                 out_ch.frame_state, want.frame_state));
        end
      end
    end
  end

  // Watchdog: a long run of cycles with no transaction on either channel means
  // the block has hung or a result was lost.
  always @(negedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("[%0t] no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("dmx_frame_channel_receiver_tb NOT OK");
      $finish;
    end
  end

endmodule
